/* rtl/core/station_mac_table_core_defines.svh */
// assertion macros for the station mac table checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef STATION_MAC_TABLE_CORE_DEFINES_SVH
`define STATION_MAC_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("station mac table check failed");

// next-cycle implication, checked out of reset
`define SMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("station mac table check failed");

`endif

/* rtl/core/smt_pkg.sv */
// shared types, codes and sizes for the station mac table
// no dependencies
`default_nettype none

package smt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAC_BYTES   = 6;

  localparam int MAC_W   = 48;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;
  localparam int MAXE_W  = 5;
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);

  // only the low MAC_BYTES bytes take part in a compare
  localparam logic [MAC_W-1:0] KEY_MASK =
    (MAC_BYTES * 8 >= MAC_W) ? {MAC_W{1'b1}} :
    MAC_W'((64'd1 << (MAC_BYTES * 8)) - 64'd1);

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MAC_W-1:0]  mac;
  } smt_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
  } smt_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/station_mac_table_core.sv */
// from accept to result strobe: add, refused add and unused kind go through the exec state;
// search/delete scan each entry (one ram read, one compare each), plus an end check on a miss;
// delete then moves each later entry up (read then write through the ram port).
// busy stays high for the whole request; the next beat is taken in the strobe cycle.
// reset: entry count 0, max entries 16; stored addresses are undefined until written.
`default_nettype none

module station_mac_table_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire smt_pkg::smt_req_t           in_data,
  output logic                             out_strobe,
  output smt_pkg::smt_rsp_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic [smt_pkg::MAXE_W-1:0]  cfg_wdata
);

  import smt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SH_RD = 3'd4;
  localparam logic [2:0] S_SH_WR = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [MAXE_W-1:0] max_r;
  smt_req_t          req_r, req_nxt;
  smt_rsp_t          rsp_r, rsp_nxt;
  logic              strobe_r, strobe_nxt;

  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  idx_inc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [MAC_W-1:0]  ram_wdata;
  logic [MAC_W-1:0]  ram_rdata;
  logic              hit;

  smt_ram #(
    .WIDTH (MAC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // capacity saturates at the table depth
  assign cap = (max_r > MAXE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(max_r);
  assign idx_inc = idx_r + CNT_W'(1);
  assign hit = ((ram_rdata ^ req_r.mac) & KEY_MASK) == '0;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    req_nxt    = req_r;
    rsp_nxt    = rsp_r;
    strobe_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[ADDR_W-1:0];
    ram_wdata  = req_r.mac;
    ram_raddr  = idx_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_r.kind)
          KIND_ADD: begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            if (count_r >= cap) begin
              rsp_nxt = '{status: ST_FULL, position: '0, entry_count: count_r};
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[ADDR_W-1:0];
              count_nxt = count_r + CNT_W'(1);
              rsp_nxt   = '{status: ST_ADDED, position: count_r[POS_W-1:0],
                            entry_count: count_r + CNT_W'(1)};
            end
          end
          KIND_DELETE, KIND_SEARCH: begin
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            rsp_nxt    = '{status: ST_NOT_FOUND, position: '0, entry_count: count_r};
          end
        endcase
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          rsp_nxt    = '{status: ST_NOT_FOUND, position: '0, entry_count: count_r};
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (hit) begin
          pos_nxt = idx_r[POS_W-1:0];
          if (req_r.kind == KIND_SEARCH) begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            rsp_nxt    = '{status: ST_FOUND, position: idx_r[POS_W-1:0],
                           entry_count: count_r};
          end else begin
            state_nxt = S_SH_RD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN;
        end
      end
      S_SH_RD: begin
        // last entry reached: the tail simply drops off
        if (idx_inc >= count_r) begin
          count_nxt  = count_r - CNT_W'(1);
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          rsp_nxt    = '{status: ST_DELETED, position: pos_r,
                         entry_count: count_r - CNT_W'(1)};
        end else begin
          ram_raddr = idx_inc[ADDR_W-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = S_SH_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      max_r    <= MAXE_W'(TABLE_DEPTH);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = rsp_r;

endmodule

`default_nettype wire

/* rtl/core/smt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module smt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/smt_checker.sv */
// port-level checks for the station mac table core, bound to the core module
// depends on smt_pkg and station_mac_table_core_defines.svh
`default_nettype none

`include "station_mac_table_core_defines.svh"

module smt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_strobe,
  input wire smt_pkg::smt_rsp_t          out_data
);

  import smt_pkg::*;

  // an accepted beat always occupies the core
  `SMT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // a result only ever closes a busy period
  `SMT_ASSERT_IMP(a_strobe_after_busy, out_strobe, $past(busy))
  `SMT_ASSERT_IMP(a_busy_end_strobe, $fell(busy), out_strobe)
  `SMT_ASSERT_IMP(a_count_range, out_strobe, out_data.entry_count <= CNT_W'(TABLE_DEPTH))
  // misses and refusals carry no position
  `SMT_ASSERT_IMP(a_no_pos_on_miss,
                  out_strobe && (out_data.status == ST_FULL ||
                                 out_data.status == ST_NOT_FOUND),
                  out_data.position == '0)

endmodule

bind station_mac_table_core smt_checker u_smt_checker (.*);

`default_nettype wire
